@@ rtl/blpt_pkg.sv @@
// ----------------------------------------------------------------------------
// blpt_pkg: shared types and constants of the LED blink pattern timer
// Item layouts, timer state, register map and pattern codes.
// ----------------------------------------------------------------------------
package blpt_pkg;

  localparam int unsigned PhaseW = 14;
  localparam int unsigned MsW    = 10;
  localparam int unsigned SecW   = 16;
  localparam int unsigned LevelW = 8;

  // Input item modes
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeStop  = 2'd2;

  // Pattern codes
  localparam logic [1:0] PatRedFast  = 2'd0;
  localparam logic [1:0] PatRedSolid = 2'd1;
  localparam logic [1:0] PatBlueFast = 2'd2;
  localparam logic [1:0] PatBlueSlow = 2'd3;
  localparam logic [2:0] NoPattern   = 3'd4;

  localparam logic [MsW-1:0] MsPerSecondM1 = MsW'(999);
  localparam logic [SecW-1:0] SecMax       = '1;

  // Register indexes
  localparam logic [1:0] RegFastOn  = 2'd0;
  localparam logic [1:0] RegFastOff = 2'd1;
  localparam logic [1:0] RegSlowOn  = 2'd2;
  localparam logic [1:0] RegSlowOff = 2'd3;

  localparam logic [PhaseW-1:0] FastOnReset  = PhaseW'(150);
  localparam logic [PhaseW-1:0] FastOffReset = PhaseW'(150);
  localparam logic [PhaseW-1:0] SlowOnReset  = PhaseW'(500);
  localparam logic [PhaseW-1:0] SlowOffReset = PhaseW'(1500);

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        pattern;
    logic [SecW-1:0]   run_secs;
    logic [LevelW-1:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] blue_level;
    logic              running;
    logic [2:0]        pattern_now;
    logic [SecW-1:0]   duration_now;
    logic              rejected;
  } out_item_t;

  typedef struct packed {
    logic [PhaseW-1:0] fast_on;
    logic [PhaseW-1:0] fast_off;
    logic [PhaseW-1:0] slow_on;
    logic [PhaseW-1:0] slow_off;
  } phase_cfg_t;

  typedef struct packed {
    logic              active;
    logic [1:0]        pattern_held;
    logic [SecW-1:0]   duration_held;
    logic [LevelW-1:0] level_held;
    logic [MsW-1:0]    millis_in_second;
    logic [SecW-1:0]   seconds_elapsed;
    logic              in_off_phase;
    logic [PhaseW-1:0] phase_millis;
  } timer_state_t;

  localparam timer_state_t IdleState = '0;

endpackage

@@ rtl/blpt_step.sv @@
// ----------------------------------------------------------------------------
// blpt_step: next-state and result logic for one item
// Applies a tick, start or stop to the timer state and forms the result.
// ----------------------------------------------------------------------------
module blpt_step (
  input  blpt_pkg::timer_state_t state_i,
  input  blpt_pkg::phase_cfg_t   cfg_i,
  input  blpt_pkg::in_item_t     item_i,
  output blpt_pkg::timer_state_t state_o,
  output blpt_pkg::out_item_t    result_o
);

  logic [blpt_pkg::PhaseW:0]   phase_inc;
  logic [blpt_pkg::PhaseW-1:0] phase_len;
  logic [blpt_pkg::PhaseW-1:0] phase_raw;
  logic                        slow;
  logic                        rejected;
  logic [blpt_pkg::LevelW-1:0] level;
  logic                        red;
  blpt_pkg::timer_state_t      nx;

  always_comb begin
    nx        = state_i;
    rejected  = 1'b0;
    slow      = (state_i.pattern_held == blpt_pkg::PatBlueSlow);
    phase_inc = {1'b0, state_i.phase_millis} + 1'b1;
    if (state_i.in_off_phase) begin
      phase_raw = slow ? cfg_i.slow_off : cfg_i.fast_off;
    end else begin
      phase_raw = slow ? cfg_i.slow_on : cfg_i.fast_on;
    end
    // a zero length acts as one tick
    phase_len = (phase_raw == '0) ? blpt_pkg::PhaseW'(1) : phase_raw;

    priority if (item_i.mode == blpt_pkg::ModeTick) begin
      if (state_i.active) begin
        if (state_i.millis_in_second == blpt_pkg::MsPerSecondM1) begin
          nx.millis_in_second = '0;
          if (state_i.seconds_elapsed != blpt_pkg::SecMax) begin
            nx.seconds_elapsed = state_i.seconds_elapsed + 1'b1;
          end
        end else begin
          nx.millis_in_second = state_i.millis_in_second + 1'b1;
        end
        if (state_i.duration_held != '0 && nx.seconds_elapsed >= state_i.duration_held) begin
          nx = blpt_pkg::IdleState;
        end else if (state_i.pattern_held != blpt_pkg::PatRedSolid) begin
          if (phase_inc >= {1'b0, phase_len}) begin
            nx.in_off_phase = ~state_i.in_off_phase;
            nx.phase_millis = '0;
          end else begin
            nx.phase_millis = phase_inc[blpt_pkg::PhaseW-1:0];
          end
        end
      end
    end else if (item_i.mode == blpt_pkg::ModeStart) begin
      if (item_i.pattern[2]) begin
        rejected = 1'b1;
      end else begin
        nx               = blpt_pkg::IdleState;
        nx.active        = 1'b1;
        nx.pattern_held  = item_i.pattern[1:0];
        nx.duration_held = item_i.run_secs;
        nx.level_held    = item_i.brightness;
      end
    end else if (item_i.mode == blpt_pkg::ModeStop) begin
      nx = blpt_pkg::IdleState;
    end else begin
      nx = state_i;
    end

    level = (nx.active && !nx.in_off_phase) ? nx.level_held : '0;
    red   = (nx.pattern_held == blpt_pkg::PatRedFast) ||
            (nx.pattern_held == blpt_pkg::PatRedSolid);

    result_o.red_level    = red ? level : '0;
    result_o.blue_level   = red ? '0 : level;
    result_o.running      = nx.active;
    result_o.pattern_now  = nx.active ? {1'b0, nx.pattern_held} : blpt_pkg::NoPattern;
    result_o.duration_now = nx.active ? nx.duration_held : '0;
    result_o.rejected     = rejected;
    state_o               = nx;
  end

endmodule

@@ rtl/led_blink_pattern_timer.sv @@
// ----------------------------------------------------------------------------
// led_blink_pattern_timer: red/blue LED blink pattern timer
// Runs one of four LED patterns from 1 ms ticks and start/stop items.
// ----------------------------------------------------------------------------
// Every item (a 1 ms tick, a start or a stop) updates the timer state and
// the result at the edge that accepts it, so items may arrive in every
// cycle unless the output stalls, and each result appears in the cycle
// after. With the single result register, a new item is taken whenever
// that register is empty or its result is being taken in the same cycle.
// Blink phase lengths come from four APB registers (fast on, fast off,
// slow on, slow off, in ticks; 0 behaves like 1) at byte addresses 0, 4,
// 8 and 12. A start with an invalid pattern reports rejected and changes
// nothing; a valid start restarts timing in the on phase.
module led_blink_pattern_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  blpt_pkg::in_item_t  in_item_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output blpt_pkg::out_item_t out_item_o,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  blpt_pkg::phase_cfg_t   cfg_q;
  blpt_pkg::timer_state_t state_q, state_d;
  blpt_pkg::out_item_t    out_q, out_d;
  logic                   out_valid_q;
  logic                   in_fire;
  logic                   cfg_wr;
  logic [1:0]             reg_idx;
  logic [blpt_pkg::PhaseW-1:0] rd_val;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign cfg_wr   = psel && penable && pwrite;

  // accept while the result slot is empty or draining this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  blpt_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_item_i),
    .state_o  (state_d),
    .result_o (out_d)
  );

  // register readback
  always_comb begin
    unique case (reg_idx)
      blpt_pkg::RegFastOn:  rd_val = cfg_q.fast_on;
      blpt_pkg::RegFastOff: rd_val = cfg_q.fast_off;
      blpt_pkg::RegSlowOn:  rd_val = cfg_q.slow_on;
      blpt_pkg::RegSlowOff: rd_val = cfg_q.slow_off;
      default:              rd_val = '0;
    endcase
    prdata = {{(32 - blpt_pkg::PhaseW){1'b0}}, rd_val};
  end

  // phase length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_on  <= blpt_pkg::FastOnReset;
      cfg_q.fast_off <= blpt_pkg::FastOffReset;
      cfg_q.slow_on  <= blpt_pkg::SlowOnReset;
      cfg_q.slow_off <= blpt_pkg::SlowOffReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        blpt_pkg::RegFastOn:  cfg_q.fast_on  <= pwdata[blpt_pkg::PhaseW-1:0];
        blpt_pkg::RegFastOff: cfg_q.fast_off <= pwdata[blpt_pkg::PhaseW-1:0];
        blpt_pkg::RegSlowOn:  cfg_q.slow_on  <= pwdata[blpt_pkg::PhaseW-1:0];
        blpt_pkg::RegSlowOff: cfg_q.slow_off <= pwdata[blpt_pkg::PhaseW-1:0];
        default: ;
      endcase
    end
  end

  // timer state advances only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blpt_pkg::IdleState;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // result slot: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

endmodule

@@ bench/led_blink_pattern_timer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pattern_timer_test: self-checking bench for the LED pattern timer
// Drives tick, start and stop items through the valid/ready input, programs
// the four phase lengths over APB between phases, and checks every status
// item against a cycle-free model of the pattern timer kept in a scoreboard.
// ----------------------------------------------------------------------------
module led_blink_pattern_timer_test;

  localparam int unsigned ClkPeriod      = 8;
  localparam int unsigned PhaseCount     = 8;
  localparam int unsigned ItemsPerPhase  = 40;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned TailCycles     = 8;
  localparam logic [blpt_pkg::PhaseW-1:0] LenMax  = '1;
  localparam logic [blpt_pkg::PhaseW-1:0] LenHigh = blpt_pkg::PhaseW'(10000);
  // mode code the block has no use for
  localparam logic [1:0] ModeSpare = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the timer state and the phase lengths, turns each
  // accepted item into the status the block should report, and compares.
  // --------------------------------------------------------------------------
  class status_scoreboard;
    blpt_pkg::phase_cfg_t   lengths;
    blpt_pkg::timer_state_t timer;
    blpt_pkg::out_item_t    status_due[$];
    int unsigned            errors;

    function new();
      lengths = '{fast_on: blpt_pkg::FastOnReset, fast_off: blpt_pkg::FastOffReset,
                  slow_on: blpt_pkg::SlowOnReset, slow_off: blpt_pkg::SlowOffReset};
      timer   = blpt_pkg::IdleState;
      errors  = 0;
    endfunction

    function void set_length(logic [1:0] idx, logic [31:0] value);
      case (idx)
        blpt_pkg::RegFastOn:  lengths.fast_on  = value[blpt_pkg::PhaseW-1:0];
        blpt_pkg::RegFastOff: lengths.fast_off = value[blpt_pkg::PhaseW-1:0];
        blpt_pkg::RegSlowOn:  lengths.slow_on  = value[blpt_pkg::PhaseW-1:0];
        blpt_pkg::RegSlowOff: lengths.slow_off = value[blpt_pkg::PhaseW-1:0];
        default: ;
      endcase
    endfunction

    // a programmed length of zero lasts one tick
    function int unsigned phase_len();
      logic [blpt_pkg::PhaseW-1:0] len;
      if (timer.pattern_held == blpt_pkg::PatBlueSlow) begin
        len = timer.in_off_phase ? lengths.slow_off : lengths.slow_on;
      end else begin
        len = timer.in_off_phase ? lengths.fast_off : lengths.fast_on;
      end
      return (len == '0) ? 1 : len;
    endfunction

    function void advance_one_ms();
      if (!timer.active) return;
      if (timer.millis_in_second == blpt_pkg::MsPerSecondM1) begin
        timer.millis_in_second = '0;
        if (timer.seconds_elapsed != blpt_pkg::SecMax) begin
          timer.seconds_elapsed = timer.seconds_elapsed + 1'b1;
        end
      end else begin
        timer.millis_in_second = timer.millis_in_second + 1'b1;
      end
      if (timer.duration_held != '0 && timer.seconds_elapsed >= timer.duration_held) begin
        timer = blpt_pkg::IdleState;
        return;
      end
      if (timer.pattern_held == blpt_pkg::PatRedSolid) return;
      timer.phase_millis = timer.phase_millis + 1'b1;
      if (timer.phase_millis >= phase_len()) begin
        timer.in_off_phase = ~timer.in_off_phase;
        timer.phase_millis = '0;
      end
    endfunction

    function void note_item(blpt_pkg::in_item_t item);
      logic [blpt_pkg::LevelW-1:0] lvl;
      logic                        rej;
      blpt_pkg::out_item_t         want;
      rej = 1'b0;
      case (item.mode)
        blpt_pkg::ModeTick: advance_one_ms();
        blpt_pkg::ModeStart: begin
          if (item.pattern >= blpt_pkg::NoPattern) begin
            rej = 1'b1;
          end else begin
            timer               = blpt_pkg::IdleState;
            timer.active        = 1'b1;
            timer.pattern_held  = item.pattern[1:0];
            timer.duration_held = item.run_secs;
            timer.level_held    = item.brightness;
          end
        end
        blpt_pkg::ModeStop: timer = blpt_pkg::IdleState;
        default: ;
      endcase
      lvl = (timer.active && !timer.in_off_phase) ? timer.level_held : '0;
      want.red_level    = (timer.pattern_held <= blpt_pkg::PatRedSolid) ? lvl : '0;
      want.blue_level   = (timer.pattern_held <= blpt_pkg::PatRedSolid) ? '0 : lvl;
      want.running      = timer.active;
      want.pattern_now  = timer.active ? {1'b0, timer.pattern_held} : blpt_pkg::NoPattern;
      want.duration_now = timer.active ? timer.duration_held : '0;
      want.rejected     = rej;
      status_due.push_back(want);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_status(blpt_pkg::out_item_t got);
      blpt_pkg::out_item_t want;
      if (status_due.size() == 0) begin
        $display("%0t: status item with none expected, got %p", $time, got);
        errors++;
        return;
      end
      want = status_due.pop_front();
      compare_field("red_level", 32'(want.red_level), 32'(got.red_level));
      compare_field("blue_level", 32'(want.blue_level), 32'(got.blue_level));
      compare_field("running", 32'(want.running), 32'(got.running));
      compare_field("pattern_now", 32'(want.pattern_now), 32'(got.pattern_now));
      compare_field("duration_now", 32'(want.duration_now), 32'(got.duration_now));
      compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  blpt_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  blpt_pkg::out_item_t out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  status_scoreboard board = new();

  // idling controls, set by the stimulus per phase
  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;
  bit          rx_hold_req  = 1'b0;
  int unsigned phase_items  = 0;

  led_blink_pattern_timer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  // Gap length for either side: mostly short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic blpt_pkg::in_item_t make_item(logic [1:0] mode, logic [2:0] pat,
                                                   logic [blpt_pkg::SecW-1:0] dur,
                                                   logic [blpt_pkg::LevelW-1:0] bri);
    blpt_pkg::in_item_t item;
    item.mode       = mode;
    item.pattern    = pat;
    item.run_secs   = dur;
    item.brightness = bri;
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: drive ready at the falling edge, take items at the rising
  // edge. A hold request drops ready for a long stretch so the single result
  // register fills and the input stalls.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
        // this cycle counts as the first one of the stall
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_status(out_item);
  end

  // --------------------------------------------------------------------------
  // Item side. Every task below is entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one item, hold it until taken, then maybe drop valid for a gap.
  task automatic push_item(blpt_pkg::in_item_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_item(item);
    // ignored items do not advance the phase count
    if (item.mode != ModeSpare &&
        !(item.mode == blpt_pkg::ModeStart && item.pattern >= blpt_pkg::NoPattern)) begin
      phase_items++;
    end
    @(negedge clk);
    gap = (tx_gaps_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic tick_run(int unsigned n);
    repeat (n) begin
      push_item(make_item(blpt_pkg::ModeTick, 3'($urandom_range(0, 7)),
                          blpt_pkg::SecW'($urandom_range(0, 65535)),
                          blpt_pkg::LevelW'($urandom_range(0, 255))));
    end
  endtask

  task automatic start_pattern(logic [2:0] pat, logic [blpt_pkg::SecW-1:0] dur);
    push_item(make_item(blpt_pkg::ModeStart, pat, dur,
                        blpt_pkg::LevelW'($urandom_range(0, 255))));
  endtask

  // Drop valid and hold off until every status item has come back.
  task automatic wait_all_status();
    in_valid <= 1'b0;
    while (board.status_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_length(logic [1:0] idx, logic [blpt_pkg::PhaseW-1:0] len);
    logic [31:0] data;
    // junk in the upper bits must be dropped by the register
    data                       = $urandom();
    data[blpt_pkg::PhaseW-1:0] = len;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_length(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_lengths(logic [blpt_pkg::PhaseW-1:0] fast_on,
                                 logic [blpt_pkg::PhaseW-1:0] fast_off,
                                 logic [blpt_pkg::PhaseW-1:0] slow_on,
                                 logic [blpt_pkg::PhaseW-1:0] slow_off);
    write_length(blpt_pkg::RegFastOn, fast_on);
    write_length(blpt_pkg::RegFastOff, fast_off);
    write_length(blpt_pkg::RegSlowOn, slow_on);
    write_length(blpt_pkg::RegSlowOff, slow_off);
  endtask

  // One random sequence. Most are a valid start followed by a run of ticks,
  // so blinking and phase flips get real coverage; the rest are stops,
  // rejected starts, spare-mode items and bare tick runs.
  task automatic run_sequence();
    int unsigned r;
    logic [blpt_pkg::SecW-1:0] dur;
    r = $urandom_range(0, 99);
    if (r < 68) begin
      r = $urandom_range(0, 9);
      if (r < 4) dur = '0;
      else if (r == 4) dur = blpt_pkg::SecW'(1);
      else dur = blpt_pkg::SecW'($urandom_range(0, 65535));
      start_pattern(3'($urandom_range(0, 3)), dur);
      tick_run($urandom_range(0, 60));
    end else if (r < 78) begin
      push_item(make_item(blpt_pkg::ModeStop, 3'($urandom_range(0, 7)),
                          blpt_pkg::SecW'($urandom_range(0, 65535)),
                          blpt_pkg::LevelW'($urandom_range(0, 255))));
      tick_run($urandom_range(0, 8));
    end else if (r < 88) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) begin
          start_pattern(3'($urandom_range(blpt_pkg::NoPattern, 7)),
                        blpt_pkg::SecW'($urandom_range(0, 65535)));
        end else begin
          push_item(make_item(ModeSpare, 3'($urandom_range(0, 7)),
                              blpt_pkg::SecW'($urandom_range(0, 65535)),
                              blpt_pkg::LevelW'($urandom_range(0, 255))));
        end
        tick_run($urandom_range(0, 3));
      end
    end else begin
      tick_run($urandom_range(1, 40));
    end
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst_n    = 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset phase lengths: idle corner cases first,
    // then every pattern with extreme fields, a rejected start and a spare
    // mode while running, and a stop.
    tick_run(1);
    push_item(make_item(blpt_pkg::ModeStop, '0, '0, '0));
    push_item(make_item(ModeSpare, '1, '1, '1));
    push_item(make_item(blpt_pkg::ModeStart, blpt_pkg::NoPattern, '0, '0));
    push_item(make_item(blpt_pkg::ModeStart, 3'b111, '1, '1));
    push_item(make_item(blpt_pkg::ModeStart, {1'b0, blpt_pkg::PatRedFast}, '0, '1));
    tick_run(1);
    push_item(make_item(blpt_pkg::ModeStart, 3'b110, 16'h5555, 8'h55));
    push_item(make_item(ModeSpare, '0, '0, '0));
    push_item(make_item(blpt_pkg::ModeStart, {1'b0, blpt_pkg::PatRedSolid}, '1, '0));
    tick_run(1);
    push_item(make_item(blpt_pkg::ModeStart, {1'b0, blpt_pkg::PatRedSolid},
                        blpt_pkg::SecW'(1), 8'h80));
    tick_run(1);
    push_item(make_item(blpt_pkg::ModeStart, {1'b0, blpt_pkg::PatBlueFast}, 16'h5555, 8'hAA));
    tick_run(1);
    push_item(make_item(blpt_pkg::ModeStart, {1'b0, blpt_pkg::PatBlueSlow}, 16'hAAAA, 8'h55));
    tick_run(1);
    push_item(make_item(blpt_pkg::ModeStop, '1, '1, '1));
    tick_run(1);
    wait_all_status();

    // Random part, in phases with different phase lengths. Every third
    // phase runs with no idling on either side.
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: ;
        1: program_lengths(blpt_pkg::PhaseW'(1), blpt_pkg::PhaseW'(1),
                           blpt_pkg::PhaseW'(1), blpt_pkg::PhaseW'(2));
        2: program_lengths('0, '0, '0, '0);
        3: program_lengths(LenMax, LenMax, LenHigh, LenHigh);
        default: begin
          program_lengths(blpt_pkg::PhaseW'($urandom_range(0, 24)),
                          blpt_pkg::PhaseW'($urandom_range(0, 24)),
                          blpt_pkg::PhaseW'($urandom_range(0, 24)),
                          blpt_pkg::PhaseW'($urandom_range(0, 24)));
        end
      endcase
      tx_gaps_on   = (ph % 3 != 0);
      rx_stalls_on = (ph % 3 != 0);
      if (ph == 0) begin
        // make sure at least one pattern runs out on its own
        start_pattern({1'b0, blpt_pkg::PatBlueSlow}, blpt_pkg::SecW'(1));
        tick_run(1005);
      end
      phase_items = 0;
      while (phase_items < ItemsPerPhase) begin
        if (ph == 3 && !hold_done && phase_items > ItemsPerPhase / 2) begin
          // stall the result side while items keep coming
          rx_hold_req = 1'b1;
          hold_done   = 1'b1;
        end
        if (ph == 5 && !pause_done && phase_items > ItemsPerPhase / 2) begin
          wait_all_status();
          pause_done = 1'b1;
        end
        run_sequence();
      end
      wait_all_status();
    end

    repeat (TailCycles) @(negedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
